[src/bgf_pkg.sv]
// ----------------------------------------------------------------------------
// bgf_pkg
// Types, constants and lookup functions shared by the battery gauge filter.
// ----------------------------------------------------------------------------
package bgf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 19;
  localparam int FILT_W   = 23;
  localparam int MV_W     = 15;
  localparam int PCT_W    = 7;
  localparam int BAR_W    = 5;
  localparam int LEVEL_W  = 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(435597);
  localparam logic [FILT_W-1:0] FILT_MAX   = '1;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;

  // Division by 20 as a reciprocal multiply; exact for any 23-bit dividend.
  localparam int DIV20_SHIFT = 27;
  localparam logic [MUL_W-1:0] DIV20_RECIP = MUL_W'((2**27 + 19) / 20);

  // Segment slope division: quotient = (u * recip) >> SEG_SHIFT, u < 2^15.
  localparam int SEG_SHIFT = 28;
  localparam int RECIP_W   = 20;
  localparam logic [RECIP_W-1:0] RECIP_700  = RECIP_W'((2**28 + 699) / 700);
  localparam logic [RECIP_W-1:0] RECIP_800  = RECIP_W'((2**28 + 799) / 800);
  localparam logic [RECIP_W-1:0] RECIP_400  = RECIP_W'((2**28 + 399) / 400);
  localparam logic [RECIP_W-1:0] RECIP_600  = RECIP_W'((2**28 + 599) / 600);
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'((2**28 + 999) / 1000);
  localparam logic [RECIP_W-1:0] RECIP_2000 = RECIP_W'((2**28 + 1999) / 2000);

  // Bar width: pct * BAR_PIXELS / 100, folded into one constant multiplier.
  localparam int BAR_PIXELS = 16;
  localparam int BAR_SHIFT  = 22;
  localparam int BAR_RECIP  = (2**22 + 99) / 100;
  localparam logic [MUL_W-1:0] BAR_MULT = MUL_W'(BAR_PIXELS * BAR_RECIP);
  localparam logic [BAR_W-1:0] BAR_MAX  = '1;

  // Curve breakpoints in Q8 millivolts.
  localparam logic [FILT_W-1:0] V_FULL  = FILT_W'(16700 * 256);
  localparam logic [FILT_W-1:0] V_EMPTY = FILT_W'(11200 * 256);
  localparam logic [FILT_W-1:0] V_16000 = FILT_W'(16000 * 256);
  localparam logic [FILT_W-1:0] V_15200 = FILT_W'(15200 * 256);
  localparam logic [FILT_W-1:0] V_14800 = FILT_W'(14800 * 256);
  localparam logic [FILT_W-1:0] V_14200 = FILT_W'(14200 * 256);
  localparam logic [FILT_W-1:0] V_13200 = FILT_W'(13200 * 256);

  localparam logic [PCT_W-1:0] PCT_FULL      = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_EMPTY     = PCT_W'(0);
  localparam logic [PCT_W-1:0] PCT_LOW_MAX   = PCT_W'(20);
  localparam logic [PCT_W-1:0] PCT_WARN_MAX  = PCT_W'(35);

  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_WARN = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_GOOD = 2'd2;

  // Datapath operation codes, one per controller step.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_MUL_X  = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV_F  = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_X  = 4'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 4'd4;
  localparam logic [OP_W-1:0] OP_SEG    = 4'd5;
  localparam logic [OP_W-1:0] OP_SLOPE  = 4'd6;
  localparam logic [OP_W-1:0] OP_QUOT   = 4'd7;
  localparam logic [OP_W-1:0] OP_PCT    = 4'd8;
  localparam logic [OP_W-1:0] OP_BAR    = 4'd9;
  localparam logic [OP_W-1:0] OP_OUT    = 4'd10;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic res_busy;
  } status_t;

  typedef struct packed {
    logic [PCT_W-1:0]   base;
    logic [FILT_W-1:0]  bp;
    logic [4:0]         num;
    logic [RECIP_W-1:0] recip;
  } seg_t;

  function automatic seg_t seg_lookup(input logic [FILT_W-1:0] v);
    seg_t s;
    if (v > V_16000) begin
      s = '{base: PCT_W'(90), bp: V_16000, num: 5'd10, recip: RECIP_700};
    end else if (v > V_15200) begin
      s = '{base: PCT_W'(75), bp: V_15200, num: 5'd15, recip: RECIP_800};
    end else if (v > V_14800) begin
      s = '{base: PCT_W'(50), bp: V_14800, num: 5'd25, recip: RECIP_400};
    end else if (v > V_14200) begin
      s = '{base: PCT_W'(30), bp: V_14200, num: 5'd20, recip: RECIP_600};
    end else if (v > V_13200) begin
      s = '{base: PCT_W'(15), bp: V_13200, num: 5'd15, recip: RECIP_1000};
    end else begin
      s = '{base: PCT_W'(0), bp: V_EMPTY, num: 5'd15, recip: RECIP_2000};
    end
    return s;
  endfunction

endpackage

[src/bgf_if.sv]
// ----------------------------------------------------------------------------
// bgf channel interfaces
// Valid/ready channels for samples, results and the gain register write.
// ----------------------------------------------------------------------------
interface bgf_sample_if import bgf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface bgf_result_if import bgf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MV_W-1:0]    filtered_mv;
  logic [PCT_W-1:0]   percent;
  logic [BAR_W-1:0]   bar_fill;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output filtered_mv, output percent, output bar_fill,
                  output level, input ready);
  modport sink (input valid, input filtered_mv, input percent, input bar_fill,
                input level, output ready);
endinterface

interface bgf_cfg_if import bgf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] adc_gain_q16;

  modport source (output valid, output adc_gain_q16, input ready);
  modport sink (input valid, input adc_gain_q16, output ready);
endinterface

[src/battery_gauge_filter.sv]
// ----------------------------------------------------------------------------
// battery_gauge_filter
// Battery sample scaling, exponential filter and state-of-charge gauge.
// ----------------------------------------------------------------------------
// A sample is accepted only while the controller is idle: it steps one shared
// 24x24 multiplier through the scale, divide and gauge operations, and holds
// in its last step while the output register still holds an untaken result.
// A finished result waits in an output register while the next sample runs.
// Reset (synchronous, active high) restores the gain and clears the filter.
module battery_gauge_filter import bgf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  bgf_cfg_if.sink             cfg,
  bgf_sample_if.sink          sample,
  bgf_result_if.source        result
);

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  bgf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bgf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg.valid),
    .cfg_gain    (cfg.adc_gain_q16),
    .adc_sample  (sample.adc_sample),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .filtered_mv (result.filtered_mv),
    .percent     (result.percent),
    .bar_fill    (result.bar_fill),
    .level       (result.level)
  );

endmodule

[src/bgf_ctrl.sv]
// ----------------------------------------------------------------------------
// bgf_ctrl
// Step sequencer: walks the datapath through one sample's operations.
// ----------------------------------------------------------------------------
module bgf_ctrl import bgf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_X  = 4'd1;
  localparam logic [3:0] ST_DIV_F  = 4'd2;
  localparam logic [3:0] ST_DIV_X  = 4'd3;
  localparam logic [3:0] ST_UPDATE = 4'd4;
  localparam logic [3:0] ST_SEG    = 4'd5;
  localparam logic [3:0] ST_SLOPE  = 4'd6;
  localparam logic [3:0] ST_QUOT   = 4'd7;
  localparam logic [3:0] ST_PCT    = 4'd8;
  localparam logic [3:0] ST_BAR    = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X:  begin cmd.op = OP_MUL_X;  state_next = ST_DIV_F;  end
      ST_DIV_F:  begin cmd.op = OP_DIV_F;  state_next = ST_DIV_X;  end
      ST_DIV_X:  begin cmd.op = OP_DIV_X;  state_next = ST_UPDATE; end
      ST_UPDATE: begin cmd.op = OP_UPDATE; state_next = ST_SEG;    end
      ST_SEG:    begin cmd.op = OP_SEG;    state_next = ST_SLOPE;  end
      ST_SLOPE:  begin cmd.op = OP_SLOPE;  state_next = ST_QUOT;   end
      ST_QUOT:   begin cmd.op = OP_QUOT;   state_next = ST_PCT;    end
      ST_PCT:    begin cmd.op = OP_PCT;    state_next = ST_BAR;    end
      ST_BAR:    begin cmd.op = OP_BAR;    state_next = ST_OUT;    end
      ST_OUT: begin
        // Hold here until the result register is free to take the item.
        if (!status.res_busy) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/bgf_datapath.sv]
// ----------------------------------------------------------------------------
// bgf_datapath
// Gain register, filter state, shared multiplier and the result register.
// ----------------------------------------------------------------------------
module bgf_datapath import bgf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                cfg_valid,
  input  logic [GAIN_W-1:0]   cfg_gain,
  input  logic [SAMPLE_W-1:0] adc_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MV_W-1:0]     filtered_mv,
  output logic [PCT_W-1:0]    percent,
  output logic [BAR_W-1:0]    bar_fill,
  output logic [LEVEL_W-1:0]  level
);

  logic [GAIN_W-1:0]   gain;
  logic [SAMPLE_W-1:0] sample_r;
  logic [FILT_W-1:0]   x_r;
  logic [FILT_W-1:0]   filt;
  logic                primed;
  logic [18:0]         qf;
  logic [18:0]         diff;
  seg_t                seg_r;
  logic                full_r;
  logic                empty_r;
  logic [PCT_W-1:0]    pct;
  logic [PROD_W-1:0]   prod;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  seg_t                seg_now;
  logic [FILT_W-1:0]   x_sat;
  logic [18:0]         qx;
  logic [FILT_W:0]     upd_sum;
  logic [FILT_W-1:0]   filt_upd;
  logic [PCT_W-1:0]    pct_next;
  logic [7:0]          bw;
  logic [BAR_W-1:0]    bar_next;
  logic [LEVEL_W-1:0]  level_next;

  assign status.res_busy = out_valid & ~out_ready;

  always_comb begin
    unique case (cmd.op)
      OP_MUL_X: begin mul_a = MUL_W'(sample_r);       mul_b = MUL_W'(gain);        end
      OP_DIV_F: begin mul_a = MUL_W'(filt);           mul_b = DIV20_RECIP;         end
      OP_DIV_X: begin mul_a = MUL_W'(x_r);            mul_b = DIV20_RECIP;         end
      OP_SLOPE: begin mul_a = MUL_W'(diff);           mul_b = MUL_W'(seg_r.num);   end
      OP_QUOT:  begin mul_a = MUL_W'(prod[22:8]);     mul_b = MUL_W'(seg_r.recip); end
      OP_BAR:   begin mul_a = MUL_W'(pct);            mul_b = BAR_MULT;            end
      default:  begin mul_a = '0;                     mul_b = '0;                  end
    endcase
  end

  // Scaled sample from the gain product, saturated to the filter width.
  assign x_sat = (prod[PROD_W-1:FILT_W+8] != '0) ? FILT_MAX : prod[FILT_W+7:8];

  assign qx       = prod[DIV20_SHIFT+18:DIV20_SHIFT];
  assign upd_sum  = {1'b0, filt} - (FILT_W+1)'(qf) + (FILT_W+1)'(qx);
  assign filt_upd = upd_sum[FILT_W] ? FILT_MAX : upd_sum[FILT_W-1:0];

  assign seg_now = seg_lookup(filt);

  // The segment quotient reaches 25 at the top of the steepest segment.
  always_comb begin
    priority if (full_r) begin
      pct_next = PCT_FULL;
    end else if (empty_r) begin
      pct_next = PCT_EMPTY;
    end else begin
      pct_next = seg_r.base + PCT_W'(prod[SEG_SHIFT+4:SEG_SHIFT]);
    end
  end

  assign bw = prod[BAR_SHIFT+7:BAR_SHIFT];

  always_comb begin
    priority if (bw > 8'(BAR_MAX)) begin
      bar_next = BAR_MAX;
    end else if (bw == '0 && pct != '0) begin
      bar_next = BAR_W'(1);
    end else begin
      bar_next = bw[BAR_W-1:0];
    end
  end

  always_comb begin
    priority if (pct <= PCT_LOW_MAX) begin
      level_next = LEVEL_LOW;
    end else if (pct <= PCT_WARN_MAX) begin
      level_next = LEVEL_WARN;
    end else begin
      level_next = LEVEL_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RESET;
      filt      <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gain <= cfg_gain;
      end
      if (cmd.op == OP_UPDATE) begin
        filt   <= primed ? filt_upd : x_r;
        primed <= 1'b1;
      end
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= adc_sample;
    end
    if (cmd.op != OP_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.op == OP_DIV_F) begin
      x_r <= x_sat;
    end
    if (cmd.op == OP_DIV_X) begin
      qf <= prod[DIV20_SHIFT+18:DIV20_SHIFT];
    end
    if (cmd.op == OP_SEG) begin
      seg_r   <= seg_now;
      diff    <= 19'(filt - seg_now.bp);
      full_r  <= (filt >= V_FULL);
      empty_r <= (filt <= V_EMPTY);
    end
    if (cmd.op == OP_PCT) begin
      pct <= pct_next;
    end
    if (cmd.op == OP_OUT) begin
      filtered_mv <= filt[FILT_W-1:8];
      percent     <= pct;
      bar_fill    <= bar_next;
      level       <= level_next;
    end
  end

endmodule
